[src/ctne_pkg.sv]
// Shared types and constants for the context tree node load and evaluate block.
// Depends on nothing; used by the walk decision module and the top level.
`default_nettype none

package ctne_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    localparam logic [7:0] PROP_QG          = 8'd0;
    localparam logic [7:0] PROP_BAND        = 8'd1;
    localparam logic [7:0] PROP_LLC         = 8'd2;
    localparam logic [7:0] PROP_RESID_DELTA = 8'd3;
    localparam logic [7:0] PROP_SIBLING     = 8'd4;
    localparam logic [7:0] PROP_ACTIVITY    = 8'd5;
    localparam logic [7:0] PROP_POS_Y       = 8'd6;
    localparam logic [7:0] PROP_POS_X       = 8'd7;
    localparam logic [7:0] PROP_NEIGHBOR    = 8'd8;
    localparam logic [7:0] PROP_PREV_COEFF  = 8'd9;
    localparam logic [7:0] PROP_WEST_MAG    = 8'd10;
    localparam logic [7:0] PROP_PREV_RES    = 8'd11;

    typedef struct packed {
        logic        [15:0] qg;
        logic signed [15:0] resid_delta;
        logic        [15:0] west_mag;
        logic        [31:0] class_bytes;
        logic        [39:0] context_bytes;
    } t_features;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_NODE,
        S_POP_STK,
        S_POP_NODE,
        S_WALK,
        S_EMPTY
    } t_state;

endpackage

`default_nettype wire

[src/ctne_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none

module ctne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/ctne_walk.sv]
// Branch decision for one split node: compares the selected feature with the threshold.
// Depends on ctne_pkg for the feature word type and the property codes.
`default_nettype none

module ctne_walk (
    input  wire logic [7:0]           i_node_prop,
    input  wire logic [15:0]          i_node_value,
    input  wire ctne_pkg::t_features  i_feat,
    output logic                      o_go_left
);

    import ctne_pkg::*;

    logic [7:0] t8;

    assign t8 = i_node_value[7:0];

    always_comb begin
        unique case (i_node_prop)
            PROP_QG:          o_go_left = i_feat.qg < i_node_value;
            PROP_BAND:        o_go_left = i_feat.class_bytes[7:0] == t8;
            PROP_LLC:         o_go_left = i_feat.class_bytes[15:8] < t8;
            PROP_RESID_DELTA: o_go_left = $signed({i_feat.resid_delta[15], i_feat.resid_delta})
                                          < $signed({1'b0, i_node_value});
            PROP_SIBLING:     o_go_left = i_feat.class_bytes[23:16] < t8;
            PROP_ACTIVITY:    o_go_left = i_feat.class_bytes[31:24] < t8;
            PROP_POS_Y:       o_go_left = i_feat.context_bytes[7:0] < t8;
            PROP_POS_X:       o_go_left = i_feat.context_bytes[15:8] < t8;
            PROP_NEIGHBOR:    o_go_left = i_feat.context_bytes[23:16] < t8;
            PROP_PREV_COEFF:  o_go_left = i_feat.context_bytes[31:24] < t8;
            PROP_WEST_MAG:    o_go_left = i_feat.west_mag < i_node_value;
            PROP_PREV_RES:    o_go_left = i_feat.context_bytes[39:32] < t8;
            default:          o_go_left = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[src/context_tree_node_load_and_eval_top.sv]
// Top level of the context tree node load and evaluate block: sequencer, node table,
// parent stack. Depends on ctne_pkg, ctne_ram and ctne_walk.
// Clear is done in the idle state. Append runs the link and node states, then the
// stack pop and node fetch states when a completed parent is popped and the new top
// must be fetched from the stack and the node table. Evaluate visits one tree level per
// read of the node table's single read port; the result word is registered at the end.
// Reset clears the state, node count, stack pointer and output valid; not the memories.
`default_nettype none

module context_tree_node_load_and_eval_top #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic               i_node_is_leaf,
    input  wire logic [7:0]         i_node_prop,
    input  wire logic [15:0]        i_node_value,
    input  wire logic [15:0]        i_qg,
    input  wire logic signed [15:0] i_resid_delta,
    input  wire logic [15:0]        i_west_mag,
    input  wire logic [31:0]        i_class_bytes,
    input  wire logic [39:0]        i_context_bytes,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [15:0]             o_leaf_id,
    output logic                    o_miss
);

    import ctne_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic          is_leaf;
        logic [7:0]    prop;
        logic [15:0]   value;
        logic          has_left;
        logic          has_right;
        logic [IW-1:0] left;
        logic [IW-1:0] right;
    } t_node;

    localparam int NW = $bits(t_node);

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sp, n_sp;
    logic [IW-1:0] r_top_idx, n_top_idx;
    t_node     r_top, n_top;
    logic      r_is_leaf, n_is_leaf;
    logic [7:0]  r_prop, n_prop;
    logic [15:0] r_value, n_value;
    t_features r_feat, n_feat;
    logic      r_out_valid, n_out_valid;
    logic [15:0] r_leaf_id, n_leaf_id;
    logic      r_miss, n_miss;

    logic          in_acc;
    logic          out_free;
    logic          node_we, node_re;
    logic [IW-1:0] node_waddr, node_raddr;
    t_node         node_wdata, node_rdata;
    logic [NW-1:0] node_rdata_bits;
    logic          stk_we, stk_re;
    logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    t_node         new_node, linked_top;
    logic          top_full;
    logic [CW-1:0] sp_after, sp_prev;
    logic [IW-1:0] count_idx;
    logic          go_left;
    logic [IW-1:0] walk_link;
    logic          walk_has;
    logic          walk_end;

    ctne_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_table (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_re   (node_re),
        .i_raddr(node_raddr),
        .o_rdata(node_rdata_bits)
    );

    ctne_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_parent_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (stk_re),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    ctne_walk u_walk (
        .i_node_prop (node_rdata.prop),
        .i_node_value(node_rdata.value),
        .i_feat      (r_feat),
        .o_go_left   (go_left)
    );

    assign node_rdata = t_node'(node_rdata_bits);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_leaf_id   = r_leaf_id;
    assign o_miss      = r_miss;

    assign count_idx = r_count[IW-1:0];
    assign top_full  = (r_sp != '0) && r_top.has_right;
    assign sp_after  = r_sp - CW'(top_full);
    assign sp_prev   = sp_after - CW'(1);

    assign walk_link = go_left ? node_rdata.left : node_rdata.right;
    assign walk_has  = go_left ? node_rdata.has_left : node_rdata.has_right;
    assign walk_end  = node_rdata.is_leaf || !walk_has || (CW'(walk_link) >= r_count);

    always_comb begin
        new_node           = '0;
        new_node.is_leaf   = r_is_leaf;
        new_node.prop      = r_is_leaf ? 8'd0 : r_prop;
        new_node.value     = r_value;
        linked_top         = r_top;
        if (!r_top.has_left) begin
            linked_top.has_left = 1'b1;
            linked_top.left     = count_idx;
        end else begin
            linked_top.has_right = 1'b1;
            linked_top.right     = count_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind)
                        KIND_APPEND: n_state = (r_count == CW'(MAX_NODES)) ? S_IDLE : S_LINK;
                        KIND_EVAL:   n_state = (r_count == '0) ? S_EMPTY : S_WALK;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_LINK: n_state = S_NODE;
            S_NODE: begin
                if (r_is_leaf && top_full && (sp_after != '0)) begin
                    n_state = S_POP_STK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP_STK:  n_state = S_POP_NODE;
            S_POP_NODE: n_state = S_IDLE;
            S_WALK: begin
                if (walk_end && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_sp        = r_sp;
        n_top_idx   = r_top_idx;
        n_top       = r_top;
        n_is_leaf   = r_is_leaf;
        n_prop      = r_prop;
        n_value     = r_value;
        n_feat      = r_feat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_leaf_id   = r_leaf_id;
        n_miss      = r_miss;
        node_we     = 1'b0;
        node_waddr  = r_top_idx;
        node_wdata  = linked_top;
        node_re     = 1'b0;
        node_raddr  = '0;
        stk_we      = 1'b0;
        stk_waddr   = sp_after[IW-1:0];
        stk_wdata   = count_idx;
        stk_re      = 1'b0;
        stk_raddr   = sp_prev[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_is_leaf              = i_node_is_leaf;
                    n_prop                 = i_node_prop;
                    n_value                = i_node_value;
                    n_feat.qg              = i_qg;
                    n_feat.resid_delta     = i_resid_delta;
                    n_feat.west_mag        = i_west_mag;
                    n_feat.class_bytes     = i_class_bytes;
                    n_feat.context_bytes   = i_context_bytes;
                    if (i_kind == KIND_CLEAR) begin
                        n_count = '0;
                        n_sp    = '0;
                    end
                    if ((i_kind == KIND_EVAL) && (r_count != '0)) begin
                        node_re    = 1'b1;
                        node_raddr = '0;
                    end
                end
            end
            S_LINK: begin
                if (r_sp != '0) begin
                    node_we = 1'b1;
                    n_top   = linked_top;
                end
            end
            S_NODE: begin
                node_we    = 1'b1;
                node_waddr = count_idx;
                node_wdata = new_node;
                n_count    = r_count + CW'(1);
                if (!r_is_leaf) begin
                    stk_we    = 1'b1;
                    n_sp      = sp_after + CW'(1);
                    n_top_idx = count_idx;
                    n_top     = new_node;
                end else begin
                    n_sp = sp_after;
                    if (top_full && (sp_after != '0)) begin
                        stk_re = 1'b1;
                    end
                end
            end
            S_POP_STK: begin
                n_top_idx  = stk_rdata;
                node_re    = 1'b1;
                node_raddr = stk_rdata;
            end
            S_POP_NODE: begin
                n_top = node_rdata;
            end
            S_WALK: begin
                if (!walk_end) begin
                    node_re    = 1'b1;
                    node_raddr = walk_link;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_leaf_id   = node_rdata.is_leaf ? node_rdata.value : 16'd0;
                    n_miss      = !node_rdata.is_leaf;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_leaf_id   = 16'd0;
                    n_miss      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_top_idx <= n_top_idx;
        r_top     <= n_top;
        r_is_leaf <= n_is_leaf;
        r_prop    <= n_prop;
        r_value   <= n_value;
        r_feat    <= n_feat;
        r_leaf_id <= n_leaf_id;
        r_miss    <= n_miss;
    end

    a_sp_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_count)
        else $error("Parent stack deeper than the node count.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("Node count beyond table size.");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        node_we |-> (r_state == S_LINK || r_state == S_NODE))
        else $error("Node table written outside an append.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_miss) |-> (r_leaf_id == 16'd0))
        else $error("Miss word carries a nonzero leaf id.");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == KIND_APPEND) && (r_count != CW'(MAX_NODES)))
        |=> ##2 (r_count == $past(r_count, 3) + CW'(1)))
        else $error("Append did not advance the node count.");

endmodule

`default_nettype wire

[dv/context_tree_node_load_and_eval_top_tb.sv]
// Testbench for context_tree_node_load_and_eval_top: loads random decision trees and
// checks every evaluate answer against a tree model kept in a small scoreboard class.
// Depends on ctne_pkg and the top level of the block.
`default_nettype none

module context_tree_node_load_and_eval_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctne_pkg::*;

    localparam int         NODE_SLOTS     = 64;
    localparam int         RANDOM_WORDS   = 550;
    localparam int         QUIET_AFTER    = 460;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        is_leaf;
        logic [7:0]  prop;
        logic [15:0] value;
        t_features   feats;
    } t_tree_word;

    typedef struct {
        logic [15:0] id;
        logic        miss;
    } t_leaf;

    class ctx_tree_model;
        bit          leaf_bit  [NODE_SLOTS];
        logic [7:0]  node_prop [NODE_SLOTS];
        logic [15:0] node_val  [NODE_SLOTS];
        bit          has_left  [NODE_SLOTS];
        bit          has_right [NODE_SLOTS];
        int          left_idx  [NODE_SLOTS];
        int          right_idx [NODE_SLOTS];
        int          parents   [NODE_SLOTS];
        int          n_nodes;
        int          n_parents;
        t_leaf       leaf_q [$];
        int          errors;

        function new();
            n_nodes   = 0;
            n_parents = 0;
            errors    = 0;
        endfunction

        function int pending();
            return leaf_q.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        function bit goes_left(int idx, t_features f);
            logic [15:0] t;
            logic [7:0]  t8;
            int          rd;
            int          ti;
            t  = node_val[idx];
            t8 = t[7:0];
            rd = $signed(f.resid_delta);
            ti = int'(t);
            case (node_prop[idx])
                PROP_QG:          return f.qg < t;
                PROP_BAND:        return f.class_bytes[7:0] == t8;
                PROP_LLC:         return f.class_bytes[15:8] < t8;
                PROP_RESID_DELTA: return rd < ti;
                PROP_SIBLING:     return f.class_bytes[23:16] < t8;
                PROP_ACTIVITY:    return f.class_bytes[31:24] < t8;
                PROP_POS_Y:       return f.context_bytes[7:0] < t8;
                PROP_POS_X:       return f.context_bytes[15:8] < t8;
                PROP_NEIGHBOR:    return f.context_bytes[23:16] < t8;
                PROP_PREV_COEFF:  return f.context_bytes[31:24] < t8;
                PROP_WEST_MAG:    return f.west_mag < t;
                PROP_PREV_RES:    return f.context_bytes[39:32] < t8;
                default:          return 1'b0;
            endcase
        endfunction

        function t_leaf walk(t_features f);
            t_leaf r;
            int    idx;
            r.id   = 16'd0;
            r.miss = 1'b1;
            idx    = 0;
            if (n_nodes == 0) return r;
            while (idx < n_nodes && !leaf_bit[idx]) begin
                if (goes_left(idx, f)) begin
                    if (!has_left[idx]) return r;
                    idx = left_idx[idx];
                end else begin
                    if (!has_right[idx]) return r;
                    idx = right_idx[idx];
                end
            end
            if (idx >= n_nodes) return r;
            r.id   = node_val[idx];
            r.miss = 1'b0;
            return r;
        endfunction

        function void append(t_tree_word w);
            int i;
            int p;
            i = n_nodes;
            if (i >= NODE_SLOTS) return;
            while (n_parents > 0 && has_left[parents[n_parents - 1]]
                   && has_right[parents[n_parents - 1]])
                n_parents--;
            if (n_parents > 0) begin
                p = parents[n_parents - 1];
                if (!has_left[p]) begin
                    has_left[p] = 1'b1;
                    left_idx[p] = i;
                end else if (!has_right[p]) begin
                    has_right[p] = 1'b1;
                    right_idx[p] = i;
                end
            end
            leaf_bit[i]  = w.is_leaf;
            node_prop[i] = w.is_leaf ? 8'd0 : w.prop;
            node_val[i]  = w.value;
            has_left[i]  = 1'b0;
            has_right[i] = 1'b0;
            left_idx[i]  = 0;
            right_idx[i] = 0;
            n_nodes = i + 1;
            if (!w.is_leaf && n_parents < NODE_SLOTS) begin
                parents[n_parents] = i;
                n_parents++;
            end
        endfunction

        function void note_word(t_tree_word w);
            case (w.kind)
                KIND_CLEAR: begin
                    n_nodes   = 0;
                    n_parents = 0;
                end
                KIND_APPEND: append(w);
                KIND_EVAL:   leaf_q.insert(leaf_q.size(), walk(w.feats));
                default: ;
            endcase
        endfunction

        task check_leaf(logic [15:0] id, logic miss);
            t_leaf e;
            if (leaf_q.size() == 0) begin
                report($sformatf("unexpected result word leaf_id %h miss %b", id, miss));
            end else begin
                e = leaf_q.pop_front();
                if (id !== e.id)
                    report($sformatf("leaf_id %h, expected %h", id, e.id));
                if (miss !== e.miss)
                    report($sformatf("miss %b, expected %b", miss, e.miss));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic               i_node_is_leaf;
    logic [7:0]         i_node_prop;
    logic [15:0]        i_node_value;
    logic [15:0]        i_qg;
    logic signed [15:0] i_resid_delta;
    logic [15:0]        i_west_mag;
    logic [31:0]        i_class_bytes;
    logic [39:0]        i_context_bytes;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [15:0]        o_leaf_id;
    logic               o_miss;

    ctx_tree_model   sb;
    logic [15:0]     thr_q [$];
    int              rand_count;
    int              gap_rate;
    int              stall_rate;
    int              stall_left;
    int              stuck_cycles;
    bit              quiet;

    context_tree_node_load_and_eval_top #(.MAX_NODES(NODE_SLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_node_is_leaf  (i_node_is_leaf),
        .i_node_prop     (i_node_prop),
        .i_node_value    (i_node_value),
        .i_qg            (i_qg),
        .i_resid_delta   (i_resid_delta),
        .i_west_mag      (i_west_mag),
        .i_class_bytes   (i_class_bytes),
        .i_context_bytes (i_context_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_leaf_id       (o_leaf_id),
        .o_miss          (o_miss)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_tree_word w;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_leaf(o_leaf_id, o_miss);
            if (i_in_valid && o_in_ready) begin
                w.kind                = i_kind;
                w.is_leaf             = i_node_is_leaf;
                w.prop                = i_node_prop;
                w.value               = i_node_value;
                w.feats.qg            = i_qg;
                w.feats.resid_delta   = i_resid_delta;
                w.feats.west_mag      = i_west_mag;
                w.feats.class_bytes   = i_class_bytes;
                w.feats.context_bytes = i_context_bytes;
                sb.note_word(w);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && stall_rate > 0 && $urandom_range(0, 15) < stall_rate) begin
            stall_left  <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick16();
        logic [15:0] t;
        if (thr_q.size() > 0 && $urandom_range(0, 2) == 0) begin
            t = thr_q[$urandom_range(0, thr_q.size() - 1)];
            case ($urandom_range(0, 2))
                0:       return t;
                1:       return t - 16'd1;
                default: return t + 16'd1;
            endcase
        end
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        logic [15:0] t;
        t = pick16();
        return t[7:0];
    endfunction

    function automatic t_features rand_feats();
        t_features f;
        f.qg          = pick16();
        f.resid_delta = pick16();
        f.west_mag    = pick16();
        for (int k = 0; k < 4; k++) f.class_bytes[8 * k +: 8] = pick8();
        for (int k = 0; k < 5; k++) f.context_bytes[8 * k +: 8] = pick8();
        return f;
    endfunction

    function automatic t_tree_word random_word();
        t_tree_word w;
        w.kind    = 2'($urandom);
        w.is_leaf = 1'($urandom);
        w.prop    = 8'($urandom);
        w.value   = 16'($urandom);
        w.feats   = rand_feats();
        return w;
    endfunction

    function automatic logic [7:0] pick_prop();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 11));
    endfunction

    task automatic send_word(t_tree_word w);
        i_kind          <= w.kind;
        i_node_is_leaf  <= w.is_leaf;
        i_node_prop     <= w.prop;
        i_node_value    <= w.value;
        i_qg            <= w.feats.qg;
        i_resid_delta   <= w.feats.resid_delta;
        i_west_mag      <= w.feats.west_mag;
        i_class_bytes   <= w.feats.class_bytes;
        i_context_bytes <= w.feats.context_bytes;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (w.kind != KIND_UNUSED) rand_count++;
        if (!quiet && gap_rate > 0 && $urandom_range(0, 15) < gap_rate) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_clear();
        t_tree_word w;
        w      = random_word();
        w.kind = KIND_CLEAR;
        thr_q.delete();
        send_word(w);
    endtask

    task automatic send_append(logic leaf, logic [7:0] prop, logic [15:0] value);
        t_tree_word w;
        w         = random_word();
        w.kind    = KIND_APPEND;
        w.is_leaf = leaf;
        w.prop    = prop;
        w.value   = value;
        if (!leaf) thr_q.insert(thr_q.size(), value);
        send_word(w);
    endtask

    task automatic send_eval(t_features f);
        t_tree_word w;
        w       = random_word();
        w.kind  = KIND_EVAL;
        w.feats = f;
        send_word(w);
    endtask

    task automatic send_noise();
        t_tree_word w;
        w      = random_word();
        w.kind = KIND_UNUSED;
        send_word(w);
    endtask

    task automatic build_tree(int target, bit truncate);
        int slots;
        int n;
        bit leaf;
        slots = 1;
        n     = 0;
        while (slots > 0) begin
            if (truncate && $urandom_range(0, 5) == 0) break;
            leaf = (n >= target) || ($urandom_range(0, 2) == 0);
            if (leaf) begin
                slots--;
                send_append(1'b1, 8'($urandom), pick16());
            end else begin
                slots++;
                send_append(1'b0, pick_prop(), 16'($urandom));
            end
            n++;
        end
    endtask

    task automatic run_evals(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            send_eval(rand_feats());
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        t_features f;
        int        choice;
        int        phase;
        sb              = new();
        rand_count      = 0;
        gap_rate        = 4;
        stall_rate      = 4;
        stall_left      = 0;
        stuck_cycles    = 0;
        quiet           = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_out_ready     = 1'b0;
        i_kind          = KIND_CLEAR;
        i_node_is_leaf  = 1'b0;
        i_node_prop     = 8'd0;
        i_node_value    = 16'd0;
        i_qg            = 16'd0;
        i_resid_delta   = 16'sd0;
        i_west_mag      = 16'd0;
        i_class_bytes   = 32'd0;
        i_context_bytes = 40'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_eval('0);
        send_noise();
        send_append(1'b1, 8'hFF, 16'hFFFF);
        send_eval('1);
        send_clear();
        send_append(1'b0, PROP_RESID_DELTA, 16'h0000);
        send_append(1'b1, 8'h00, 16'h0001);
        send_append(1'b0, 8'hFF, 16'hFFFF);
        f = '0;
        f.resid_delta = 16'sh7FFF;
        send_eval(f);
        send_append(1'b1, 8'h00, 16'h0003);
        send_eval(f);
        send_append(1'b1, 8'h00, 16'h0000);
        f.resid_delta = 16'sh8000;
        send_eval(f);
        send_eval('1);
        send_eval('0);
        send_clear();
        send_append(1'b0, PROP_BAND, 16'hAB12);
        send_append(1'b1, 8'h00, 16'hFFFF);
        send_append(1'b1, 8'h00, 16'h0000);
        f = '1;
        f.class_bytes[7:0] = 8'h12;
        send_eval(f);
        f.class_bytes[7:0] = 8'h13;
        send_eval(f);

        gap_rate   = 1;
        stall_rate = 1;
        send_clear();
        build_tree(NODE_SLOTS + 8, 1'b0);
        repeat (8) send_append(1'($urandom), 8'($urandom), 16'($urandom));
        run_evals(8);

        phase = 0;
        while (rand_count < RANDOM_WORDS) begin
            if (rand_count > QUIET_AFTER) begin
                quiet = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                gap_rate   = 0;
                stall_rate = 0;
            end else begin
                gap_rate   = $urandom_range(1, 6);
                stall_rate = $urandom_range(1, 6);
            end
            if (phase == 5) drain_results();
            choice = $urandom_range(0, 9);
            case (choice)
                0: repeat ($urandom_range(1, 3)) send_noise();
                1: begin
                    send_clear();
                    build_tree($urandom_range(1, 20), 1'b1);
                    run_evals($urandom_range(2, 6));
                end
                2: begin
                    build_tree($urandom_range(1, 8), 1'b0);
                    run_evals($urandom_range(2, 5));
                end
                default: begin
                    send_clear();
                    build_tree($urandom_range(1, 30), 1'b0);
                    run_evals($urandom_range(3, 10));
                end
            endcase
            phase++;
        end

        quiet = 1'b1;
        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[context_tree_node_load_and_eval_top.f]
src/ctne_pkg.sv
src/ctne_ram.sv
src/ctne_walk.sv
src/context_tree_node_load_and_eval_top.sv
dv/context_tree_node_load_and_eval_top_tb.sv
